@@ rtl/ctdv_pkg.sv @@
// shared types, constants and float helper functions for the clip test and viewport block
`timescale 1ns / 1ps

package ctdv_pkg;

  localparam logic [31:0] CanonNan   = 32'h7FC0_0000;
  localparam logic [31:0] OneFloat   = 32'h3F80_0000;
  localparam int unsigned CfgAddrW   = 3;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned DivSteps   = 26;  // quotient bits of the reciprocal
  localparam int unsigned LaneLat    = 10;  // mul, mul, add

  // configuration register indexes
  localparam logic [CfgAddrW-1:0] RegScaleX  = 3'd0;
  localparam logic [CfgAddrW-1:0] RegScaleY  = 3'd1;
  localparam logic [CfgAddrW-1:0] RegScaleZ  = 3'd2;
  localparam logic [CfgAddrW-1:0] RegOffsetX = 3'd3;
  localparam logic [CfgAddrW-1:0] RegOffsetY = 3'd4;
  localparam logic [CfgAddrW-1:0] RegOffsetZ = 3'd5;
  localparam logic [CfgAddrW-1:0] RegUserMsk = 3'd6;

  typedef struct packed {
    logic [31:0] scale_x;
    logic [31:0] scale_y;
    logic [31:0] scale_z;
    logic [31:0] offset_x;
    logic [31:0] offset_y;
    logic [31:0] offset_z;
    logic [7:0]  user_plane_mask;
  } cfg_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
    logic [13:0] clip;
  } item_t;

  typedef struct packed {
    logic [13:0] clip_bits;
    logic [31:0] win_x;
    logic [31:0] win_y;
    logic [31:0] win_z;
    logic [31:0] recip_w;
    logic [31:0] out_clip_x;
    logic [31:0] out_clip_y;
    logic [31:0] out_clip_z;
    logic [31:0] out_clip_w;
  } res_t;

  // unpacked operand: value = man * 2^(exp-23)
  typedef struct packed {
    logic               sign;
    logic               nan;
    logic               inf;
    logic               zero;
    logic signed [10:0] exp;
    logic [23:0]        man;
  } upk_t;

  // unrounded value: man[25] weight 2^exp, man[1] guard, man[0] sticky
  typedef struct packed {
    logic               sign;
    logic               nan;
    logic               inf;
    logic               zero;
    logic signed [10:0] exp;
    logic [25:0]        man;
  } ufp_t;

  typedef struct packed {
    logic               sign;
    logic               nan;
    logic               inf;
    logic               zero;
    logic signed [10:0] exp;
    logic [47:0]        prod;
  } mul_st_t;

  typedef struct packed {
    logic               sign;
    logic               effsub;
    logic               nan;
    logic               inf;
    logic               infs;
    logic signed [10:0] exp;
    logic [26:0]        ma;
    logic [26:0]        mb;
  } add_st_t;

  typedef struct packed {
    logic               sign;
    logic               effsub;
    logic               nan;
    logic               inf;
    logic               infs;
    logic signed [10:0] exp;
    logic [27:0]        sum;
  } add_sum_t;

  // reciprocal divider stage
  typedef struct packed {
    logic               sign;
    logic               nan;
    logic               inf;
    logic               zero;
    logic               exact;
    logic signed [10:0] ew;
    logic [23:0]        d;
    logic [24:0]        r;
    logic [25:0]        q;
  } rdiv_t;

  function automatic upk_t unpack(logic [31:0] a);
    upk_t u;
    u.sign = a[31];
    u.nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    u.inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    u.zero = (a[30:0] == 31'd0);
    u.man  = {a[30:23] != 8'd0, a[22:0]};
    u.exp  = (a[30:23] == 8'd0) ? -11'sd126 : ($signed({3'b000, a[30:23]}) - 11'sd127);
    return u;
  endfunction

  // leading zero count, highest set bit wins
  function automatic logic [5:0] lzc48(logic [47:0] a);
    logic [5:0] cnt;
    cnt = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (a[i]) cnt = 6'(47 - i);
    end
    return cnt;
  endfunction

  // ordered less-than on single floats
  function automatic logic flt(logic [31:0] a, logic [31:0] b);
    logic nan_a;
    logic nan_b;
    logic res;
    nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    if (nan_a || nan_b) begin
      res = 1'b0;
    end else if (a[31] != b[31]) begin
      res = a[31] && ((a[30:0] != 31'd0) || (b[30:0] != 31'd0));
    end else if (!a[31]) begin
      res = a[30:0] < b[30:0];
    end else begin
      res = a[30:0] > b[30:0];
    end
    return res;
  endfunction

  // denormal shift, round to nearest even, overflow to infinity
  function automatic logic [31:0] round_pack(ufp_t u);
    logic [25:0]        m;
    logic [25:0]        mask;
    logic signed [10:0] sh;
    logic [8:0]         bexp;
    logic               inc;
    logic [32:0]        tot;
    logic [31:0]        res;
    m    = u.man;
    mask = 26'd0;
    sh   = 11'sd0;
    bexp = 9'd0;
    inc  = 1'b0;
    tot  = 33'd0;
    if (u.nan) begin
      res = CanonNan;
    end else if (u.inf || (!u.zero && (u.man != 26'd0) && (u.exp > 11'sd127))) begin
      res = {u.sign, 8'hFF, 23'd0};
    end else if (u.zero || (u.man == 26'd0)) begin
      res = {u.sign, 31'd0};
    end else begin
      if (u.exp >= -11'sd126) begin
        bexp = 9'(u.exp + 11'sd127);
      end else begin
        sh = -11'sd126 - u.exp;
        if (sh > 11'sd25) begin
          m = {25'd0, 1'b1};
        end else begin
          mask = ~(26'h3FF_FFFF << sh[4:0]);
          m    = (u.man >> sh[4:0]) | {25'd0, |(u.man & mask)};
        end
      end
      inc = m[1] & (m[0] | m[2]);
      tot = {1'b0, bexp, 23'd0} + {10'd0, m[24:2]} + {32'd0, inc};
      if (tot[31:23] >= 9'd255) res = {u.sign, 8'hFF, 23'd0};
      else                      res = {u.sign, tot[30:0]};
    end
    return res;
  endfunction

  function automatic mul_st_t fmul_pre(logic [31:0] a, logic [31:0] b);
    upk_t    ua;
    upk_t    ub;
    mul_st_t s;
    ua     = unpack(a);
    ub     = unpack(b);
    s.sign = ua.sign ^ ub.sign;
    s.nan  = ua.nan | ub.nan | (ua.inf & ub.zero) | (ua.zero & ub.inf);
    s.inf  = ua.inf | ub.inf;
    s.zero = ua.zero | ub.zero;
    s.exp  = ua.exp + ub.exp;
    s.prod = 48'(ua.man) * 48'(ub.man);
    return s;
  endfunction

  function automatic ufp_t fmul_norm(mul_st_t s);
    logic [5:0]  l;
    logic [47:0] pn;
    ufp_t        u;
    l      = lzc48(s.prod);
    pn     = s.prod << l;
    u.sign = s.sign;
    u.nan  = s.nan;
    u.inf  = s.inf;
    u.zero = s.zero;
    u.exp  = s.exp + 11'sd1 - $signed({5'b00000, l});
    u.man  = {pn[47:23], |pn[22:0]};
    return u;
  endfunction

  function automatic add_st_t fadd_align(logic [31:0] a, logic [31:0] b);
    upk_t               big;
    upk_t               sml;
    logic signed [10:0] d;
    logic [26:0]        mb;
    logic [26:0]        mask;
    add_st_t            s;
    if (b[30:0] > a[30:0]) begin
      big = unpack(b);
      sml = unpack(a);
    end else begin
      big = unpack(a);
      sml = unpack(b);
    end
    d      = big.exp - sml.exp;
    mb     = {sml.man, 3'b000};
    mask   = 27'd0;
    s.sign = big.sign;
    s.effsub = big.sign ^ sml.sign;
    s.nan  = big.nan | sml.nan | (big.inf & sml.inf & (big.sign != sml.sign));
    s.inf  = big.inf | sml.inf;
    s.infs = big.inf ? big.sign : sml.sign;
    s.exp  = big.exp;
    s.ma   = {big.man, 3'b000};
    if (d > 11'sd26) begin
      s.mb = {26'd0, |sml.man};
    end else begin
      mask = ~(27'h7FF_FFFF << d[4:0]);
      s.mb = (mb >> d[4:0]) | {26'd0, |(mb & mask)};
    end
    return s;
  endfunction

  function automatic add_sum_t fadd_sum(add_st_t s);
    add_sum_t t;
    t.sign   = s.sign;
    t.effsub = s.effsub;
    t.nan    = s.nan;
    t.inf    = s.inf;
    t.infs   = s.infs;
    t.exp    = s.exp;
    t.sum    = s.effsub ? ({1'b0, s.ma} - {1'b0, s.mb}) : ({1'b0, s.ma} + {1'b0, s.mb});
    return t;
  endfunction

  function automatic ufp_t fadd_norm(add_sum_t t);
    logic [5:0]  l;
    logic [27:0] sn;
    ufp_t        u;
    l      = lzc48({t.sum, 20'd0});
    sn     = t.sum << l;
    u.nan  = t.nan;
    u.inf  = t.inf;
    u.zero = (t.sum == 28'd0);
    if (t.inf)                  u.sign = t.infs;
    else if (t.sum == 28'd0)    u.sign = t.effsub ? 1'b0 : t.sign;
    else                        u.sign = t.sign;
    u.exp  = t.exp + 11'sd1 - $signed({5'b00000, l});
    u.man  = {sn[27:3], |sn[2:0]};
    return u;
  endfunction

endpackage

@@ rtl/ctdv_front.sv @@
// front stage: takes position beats and forms the clip code
`timescale 1ns / 1ps

module ctdv_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  logic [127:0]         s_data_i,
  input  logic [7:0]           user_mask_i,
  output logic                 push_o,
  input  logic                 push_ready_i,
  output ctdv_pkg::item_t      item_o
);

  logic            vld_q, vld_d;
  ctdv_pkg::item_t item_q, item_d;
  logic [31:0]     x, y, z, w, nw;
  logic [5:0]      frustum;
  logic            take;

  assign x  = s_data_i[31:0];
  assign y  = s_data_i[63:32];
  assign z  = s_data_i[95:64];
  assign w  = s_data_i[127:96];
  assign nw = {~w[31], w[30:0]};

  // w - c < 0 is w < c, w + c < 0 is c < -w; exact sums never round across zero
  always_comb begin
    frustum[0] = ctdv_pkg::flt(w, x);
    frustum[1] = ctdv_pkg::flt(x, nw);
    frustum[2] = ctdv_pkg::flt(w, y);
    frustum[3] = ctdv_pkg::flt(y, nw);
    frustum[4] = ctdv_pkg::flt(w, z);
    frustum[5] = ctdv_pkg::flt(z, nw);
  end

  assign s_ready_o = ~vld_q | push_ready_i;
  assign take      = s_valid_i & s_ready_o;

  always_comb begin
    vld_d  = vld_q;
    item_d = item_q;
    if (take) begin
      vld_d       = 1'b1;
      item_d.x    = x;
      item_d.y    = y;
      item_d.z    = z;
      item_d.w    = w;
      item_d.clip = {user_mask_i, frustum};
    end else if (push_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign push_o = vld_q;
  assign item_o = item_q;

endmodule

@@ rtl/ctdv_queue.sv @@
// short queue between the front and back parts
`timescale 1ns / 1ps

module ctdv_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            ready_o,
  input  ctdv_pkg::item_t item_i,
  output logic            valid_o,
  input  logic            pop_i,
  output ctdv_pkg::item_t item_o
);

  localparam int unsigned Depth = ctdv_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);

  ctdv_pkg::item_t       mem_q [Depth];
  logic [PtrW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]         cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign ready_o = cnt_q < (PtrW+1)'(Depth);
  assign valid_o = cnt_q != '0;
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ((wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = do_pop  ? ((rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(Depth))
    else $error("queue fill beyond depth");

endmodule

@@ rtl/ctdv_lane.sv @@
// one window coordinate: c * rw, times scale, plus translate
`timescale 1ns / 1ps

module ctdv_lane (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] c_i,
  input  logic [31:0] rw_i,
  input  logic [31:0] scale_i,
  input  logic [31:0] offset_i,
  output logic [31:0] res_o
);

  ctdv_pkg::mul_st_t  m1_q [2];
  ctdv_pkg::ufp_t     m2_q [2];
  logic [31:0]        m3_q [2];
  ctdv_pkg::add_st_t  a1_q;
  ctdv_pkg::add_sum_t a2_q;
  ctdv_pkg::ufp_t     a3_q;
  logic [31:0]        res_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // first multiply: c * (1/w)
      m1_q[0] <= ctdv_pkg::fmul_pre(c_i, rw_i);
      m2_q[0] <= ctdv_pkg::fmul_norm(m1_q[0]);
      m3_q[0] <= ctdv_pkg::round_pack(m2_q[0]);
      // second multiply: scale
      m1_q[1] <= ctdv_pkg::fmul_pre(m3_q[0], scale_i);
      m2_q[1] <= ctdv_pkg::fmul_norm(m1_q[1]);
      m3_q[1] <= ctdv_pkg::round_pack(m2_q[1]);
      // translate
      a1_q    <= ctdv_pkg::fadd_align(m3_q[1], offset_i);
      a2_q    <= ctdv_pkg::fadd_sum(a1_q);
      a3_q    <= ctdv_pkg::fadd_norm(a2_q);
      res_q   <= ctdv_pkg::round_pack(a3_q);
    end
  end

  assign res_o = res_q;

endmodule

@@ rtl/ctdv_back.sv @@
// back part: reciprocal divider and the three viewport lanes, in one stall-as-a-whole pipe
`timescale 1ns / 1ps

module ctdv_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            pop_o,
  input  ctdv_pkg::item_t q_item_i,
  input  ctdv_pkg::cfg_t  cfg_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ctdv_pkg::res_t  out_o
);

  localparam int unsigned Steps = ctdv_pkg::DivSteps;
  localparam int unsigned LLat  = ctdv_pkg::LaneLat;
  localparam int unsigned RwStg = Steps + 1;          // stage holding 1/w
  localparam int unsigned Last  = RwStg + LLat;        // output stage

  logic               en;
  logic [Last:0]      vld_q;
  ctdv_pkg::rdiv_t    rd_q  [Steps+1];
  ctdv_pkg::rdiv_t    rd_n  [Steps];
  ctdv_pkg::item_t    it_q  [Steps+2];
  logic [31:0]        rw_q;
  ctdv_pkg::item_t    dit_q [LLat];
  logic [31:0]        drw_q [LLat];
  ctdv_pkg::rdiv_t    rd0;
  ctdv_pkg::upk_t     uw;
  ctdv_pkg::ufp_t     urw;
  logic [5:0]         lz;
  logic [31:0]        win_x, win_y, win_z;

  assign en    = ~vld_q[Last] | out_ready_i;
  assign pop_o = en & q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Last-1:0], q_valid_i};
    end
  end

  // normalise w so the divisor is 1.f
  always_comb begin
    uw        = ctdv_pkg::unpack(q_item_i.w);
    lz        = ctdv_pkg::lzc48({uw.man, 24'd0});
    rd0.sign  = uw.sign;
    rd0.nan   = uw.nan;
    rd0.inf   = uw.inf;
    rd0.zero  = uw.zero;
    rd0.d     = uw.man << lz;
    rd0.ew    = uw.exp - $signed({5'b00000, lz});
    rd0.exact = (rd0.d[22:0] == 23'd0);
    rd0.r     = 25'h080_0000;
    rd0.q     = '0;
  end

  // restoring division of 1.0 by the mantissa, one quotient bit a stage
  always_comb begin
    for (int k = 0; k < Steps; k++) begin
      rd_n[k] = rd_q[k];
      if ({rd_q[k].r[23:0], 1'b0} >= {1'b0, rd_q[k].d}) begin
        rd_n[k].r = {rd_q[k].r[23:0], 1'b0} - {1'b0, rd_q[k].d};
        rd_n[k].q = {rd_q[k].q[24:0], 1'b1};
      end else begin
        rd_n[k].r = {rd_q[k].r[23:0], 1'b0};
        rd_n[k].q = {rd_q[k].q[24:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_q[0] <= rd0;
      it_q[0] <= q_item_i;
      for (int k = 1; k <= Steps; k++) begin
        rd_q[k] <= rd_n[k-1];
        it_q[k] <= it_q[k-1];
      end
      it_q[Steps+1] <= it_q[Steps];
      rw_q          <= ctdv_pkg::round_pack(urw);
    end
  end

  // quotient 0.1q.. times 2^-ew, or an exact power of two
  always_comb begin
    urw.sign = rd_q[Steps].sign;
    urw.nan  = rd_q[Steps].nan;
    urw.inf  = rd_q[Steps].zero;
    urw.zero = rd_q[Steps].inf;
    if (rd_q[Steps].exact) begin
      urw.exp = -rd_q[Steps].ew;
      urw.man = {1'b1, 25'd0};
    end else begin
      urw.exp = -rd_q[Steps].ew - 11'sd1;
      urw.man = {rd_q[Steps].q[25:1], rd_q[Steps].q[0] | (rd_q[Steps].r != 25'd0)};
    end
  end

  // carry position and 1/w alongside the lanes
  always_ff @(posedge clk_i) begin
    if (en) begin
      dit_q[0] <= it_q[Steps+1];
      drw_q[0] <= rw_q;
      for (int k = 1; k < LLat; k++) begin
        dit_q[k] <= dit_q[k-1];
        drw_q[k] <= drw_q[k-1];
      end
    end
  end

  ctdv_lane u_lane_x (
    .clk_i, .en_i(en), .c_i(it_q[Steps+1].x), .rw_i(rw_q),
    .scale_i(cfg_i.scale_x), .offset_i(cfg_i.offset_x), .res_o(win_x)
  );
  ctdv_lane u_lane_y (
    .clk_i, .en_i(en), .c_i(it_q[Steps+1].y), .rw_i(rw_q),
    .scale_i(cfg_i.scale_y), .offset_i(cfg_i.offset_y), .res_o(win_y)
  );
  ctdv_lane u_lane_z (
    .clk_i, .en_i(en), .c_i(it_q[Steps+1].z), .rw_i(rw_q),
    .scale_i(cfg_i.scale_z), .offset_i(cfg_i.offset_z), .res_o(win_z)
  );

  assign out_valid_o      = vld_q[Last];
  assign out_o.clip_bits  = dit_q[LLat-1].clip;
  assign out_o.win_x      = win_x;
  assign out_o.win_y      = win_y;
  assign out_o.win_z      = win_z;
  assign out_o.recip_w    = drw_q[LLat-1];
  assign out_o.out_clip_x = dit_q[LLat-1].x;
  assign out_o.out_clip_y = dit_q[LLat-1].y;
  assign out_o.out_clip_z = dit_q[LLat-1].z;
  assign out_o.out_clip_w = dit_q[LLat-1].w;

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |-> vld_q[Last])
    else $error("pipe held without a result at the output");

endmodule

@@ rtl/clip_test_divide_viewport.sv @@
// top level: config registers, front, queue and back of the clip test and viewport block
`timescale 1ns / 1ps

// channel      | dir | beat contents (low bit first)
// -------------+-----+--------------------------------------------------------
// s_axis       | in  | pos_x, pos_y, pos_z, pos_w (4 x 32)
// m_axis       | out | clip_bits(14), win_x, win_y, win_z, recip_w,
//              |     | out_clip_x, out_clip_y, out_clip_z, out_clip_w, 2 pad
// cfg          | in  | cfg_addr_i register index, cfg_data_i value
//
// one vertex per cycle sustained while the output is ready; from the accepting input edge
// to the earliest result edge the path runs through the queue write, 27 divider stages,
// 1/w rounding and 10 lane stages
// the reciprocal divider resolves one quotient bit per stage and sets depth
// reset clears the valid bits and the config registers to their defaults
// a stalled output holds the whole back pipe; the queue lets the front keep going until it is full

module clip_test_divide_viewport (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [127:0]                   s_axis_tdata,   // pos_x, pos_y, pos_z, pos_w
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [271:0]                   m_axis_tdata,   // clip_bits, win_x/y/z, recip_w,
                                                         // out_clip_x/y/z/w, zero pad
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ctdv_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [31:0]                    cfg_data_i
);

  ctdv_pkg::cfg_t  cfg_q, cfg_d;
  ctdv_pkg::item_t f_item, q_item;
  ctdv_pkg::res_t  res;
  logic            f_push, q_ready, q_valid, b_pop;

  // config writes are always taken
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        ctdv_pkg::RegScaleX:  cfg_d.scale_x         = cfg_data_i;
        ctdv_pkg::RegScaleY:  cfg_d.scale_y         = cfg_data_i;
        ctdv_pkg::RegScaleZ:  cfg_d.scale_z         = cfg_data_i;
        ctdv_pkg::RegOffsetX: cfg_d.offset_x        = cfg_data_i;
        ctdv_pkg::RegOffsetY: cfg_d.offset_y        = cfg_data_i;
        ctdv_pkg::RegOffsetZ: cfg_d.offset_z        = cfg_data_i;
        ctdv_pkg::RegUserMsk: cfg_d.user_plane_mask = cfg_data_i[7:0];
        default:              cfg_d                 = cfg_q;  // unmapped index ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale_x         <= ctdv_pkg::OneFloat;
      cfg_q.scale_y         <= ctdv_pkg::OneFloat;
      cfg_q.scale_z         <= ctdv_pkg::OneFloat;
      cfg_q.offset_x        <= '0;
      cfg_q.offset_y        <= '0;
      cfg_q.offset_z        <= '0;
      cfg_q.user_plane_mask <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: clip code on entry
  ctdv_front u_front (
    .clk_i, .rst_ni,
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .user_mask_i (cfg_q.user_plane_mask),
    .push_o      (f_push),
    .push_ready_i(q_ready),
    .item_o      (f_item)
  );

  ctdv_queue u_queue (
    .clk_i, .rst_ni,
    .push_i (f_push),
    .ready_o(q_ready),
    .item_i (f_item),
    .valid_o(q_valid),
    .pop_i  (b_pop),
    .item_o (q_item)
  );

  // back: 1/w and the viewport lanes
  ctdv_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i  (q_valid),
    .pop_o      (b_pop),
    .q_item_i   (q_item),
    .cfg_i      (cfg_q),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_o      (res)
  );

  assign m_axis_tdata = {2'b00, res.out_clip_w, res.out_clip_z, res.out_clip_y,
                         res.out_clip_x, res.recip_w, res.win_z, res.win_y,
                         res.win_x, res.clip_bits};

  a_recip_nan_canon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[140:133] == 8'hFF) && (m_axis_tdata[132:110] != 23'd0))
    |-> (m_axis_tdata[141:110] == ctdv_pkg::CanonNan))
    else $error("reciprocal nan not canonical");

endmodule

@@ dv/tb.sv @@
// self-checking testbench for the clip test, perspective divide and viewport block
`timescale 1ns / 1ps

module tb;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;   // pos_x, pos_y, pos_z, pos_w
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [271:0] m_axis_tdata;   // clip_bits, win_x/y/z, recip_w, out_clip_x/y/z/w, pad
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [ctdv_pkg::CfgAddrW-1:0] cfg_addr_i;
  logic [31:0]                   cfg_data_i;

  clip_test_divide_viewport u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  // shadow copy of the viewport registers
  ctdv_pkg::cfg_t view_cfg;

  logic [127:0]   vertex_q[$];     // vertices waiting to be driven
  ctdv_pkg::res_t vertex_exp_q[$]; // predicted results in arrival order
  int           src_idle_pct;
  int           snk_stall_pct;
  bit           hold_req;        // ask the sink for a long stall
  int           hold_cnt;
  bit           in_fire;         // an input beat was taken at the last edge
  int           n_fail;

  // ---------------------------------------------------------------------------
  // single <-> double conversion; doubles hold single sums and products exactly
  // or round once more without harm, so each op is done in real and rounded
  // ---------------------------------------------------------------------------
  function automatic real to_double(logic [31:0] a);
    logic [7:0]  e;
    logic [22:0] f;
    int          p;
    logic [63:0] b;
    e = a[30:23];
    f = a[22:0];
    p = 0;
    if (e == 8'hFF) begin
      b = (f != 23'd0) ? 64'h7FF8_0000_0000_0000 : {a[31], 11'h7FF, 52'd0};
    end else if (e == 8'd0) begin
      if (f == 23'd0) begin
        b = {a[31], 63'd0};
      end else begin
        // denormal: value f * 2^-149, renormalise around the top set bit
        for (int i = 0; i < 23; i++) if (f[i]) p = i;
        b = {a[31], 11'(p - 149 + 1023), 52'(64'(f) << (52 - p))};
      end
    end else begin
      b = {a[31], 11'(e + 896), f, 29'd0};
    end
    return $bitstoreal(b);
  endfunction

  // round to nearest even single, denormals kept, nan made canonical
  function automatic logic [31:0] to_single(real r);
    logic [63:0] b;
    logic [63:0] mant;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] tot;
    logic        s;
    int          e;
    int          sh;
    int          base;
    b = $realtobits(r);
    s = b[63];
    e = int'(b[62:52]);
    if (e == 2047) return (b[51:0] != 52'd0) ? ctdv_pkg::CanonNan : {s, 8'hFF, 23'd0};
    if (e == 0) return {s, 31'd0};
    e = e - 1023;
    if (e > 127) return {s, 8'hFF, 23'd0};
    mant = {11'd0, 1'b1, b[51:0]};
    if (e >= -126) begin
      sh   = 29;
      base = e + 126;
    end else begin
      sh   = 29 - 126 - e;
      base = 0;
    end
    if (sh > 60) return {s, 31'd0};
    q    = mant >> sh;
    half = 64'd1 << (sh - 1);
    rem  = mant & ((64'd1 << sh) - 64'd1);
    tot  = (64'(base) << 23) + q;
    if (rem > half || (rem == half && q[0])) tot = tot + 64'd1;
    if (tot >= (64'd255 << 23)) return {s, 8'hFF, 23'd0};
    return {s, tot[30:0]};
  endfunction

  // clip bit: single sum strictly below zero (nan and -0 stay clear)
  function automatic logic plane_out(real a, real b);
    logic [31:0] t;
    t = to_single(a + b);
    return t[31] && (t[30:0] != 31'd0) && (t != ctdv_pkg::CanonNan);
  endfunction

  function automatic logic [31:0] window_coord(real c, real rw, logic [31:0] sc,
                                               logic [31:0] tr);
    real p;
    real m;
    p = to_double(to_single(c * rw));
    m = to_double(to_single(p * to_double(sc)));
    return to_single(m + to_double(tr));
  endfunction

  function automatic ctdv_pkg::res_t predict_vertex(logic [127:0] v);
    ctdv_pkg::res_t r;
    real  x;
    real  y;
    real  z;
    real  w;
    real  rw;
    x = to_double(v[31:0]);
    y = to_double(v[63:32]);
    z = to_double(v[95:64]);
    w = to_double(v[127:96]);
    r.clip_bits[0]    = plane_out(w, -x);
    r.clip_bits[1]    = plane_out(w, x);
    r.clip_bits[2]    = plane_out(w, -y);
    r.clip_bits[3]    = plane_out(w, y);
    r.clip_bits[4]    = plane_out(w, -z);
    r.clip_bits[5]    = plane_out(w, z);
    r.clip_bits[13:6] = view_cfg.user_plane_mask;
    r.recip_w         = to_single(1.0 / w);
    rw                = to_double(r.recip_w);
    r.win_x           = window_coord(x, rw, view_cfg.scale_x, view_cfg.offset_x);
    r.win_y           = window_coord(y, rw, view_cfg.scale_y, view_cfg.offset_y);
    r.win_z           = window_coord(z, rw, view_cfg.scale_z, view_cfg.offset_z);
    r.out_clip_x      = v[31:0];
    r.out_clip_y      = v[63:32];
    r.out_clip_z      = v[95:64];
    r.out_clip_w      = v[127:96];
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      n_fail++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // input driver: holds a beat until taken, idles at the phase rate
  // ---------------------------------------------------------------------------
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (vertex_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= vertex_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output sink: random stalls, plus one long counted hold-off on request
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= 0;
    end else if (hold_req) begin
      hold_req      <= 1'b0;
      hold_cnt      <= 400;
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt      <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on every input beat, compare on every output beat
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    ctdv_pkg::res_t act;
    ctdv_pkg::res_t exp_r;
    in_fire <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) vertex_exp_q.push_back(predict_vertex(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        act.clip_bits  = m_axis_tdata[13:0];
        act.win_x      = m_axis_tdata[45:14];
        act.win_y      = m_axis_tdata[77:46];
        act.win_z      = m_axis_tdata[109:78];
        act.recip_w    = m_axis_tdata[141:110];
        act.out_clip_x = m_axis_tdata[173:142];
        act.out_clip_y = m_axis_tdata[205:174];
        act.out_clip_z = m_axis_tdata[237:206];
        act.out_clip_w = m_axis_tdata[269:238];
        if (vertex_exp_q.size() == 0) begin
          $error("result beat with no vertex outstanding");
          n_fail++;
        end else begin
          exp_r = vertex_exp_q.pop_front();
          check_field("clip_bits", 32'(exp_r.clip_bits), 32'(act.clip_bits));
          check_field("win_x", exp_r.win_x, act.win_x);
          check_field("win_y", exp_r.win_y, act.win_y);
          check_field("win_z", exp_r.win_z, act.win_z);
          check_field("recip_w", exp_r.recip_w, act.recip_w);
          check_field("out_clip_x", exp_r.out_clip_x, act.out_clip_x);
          check_field("out_clip_y", exp_r.out_clip_y, act.out_clip_y);
          check_field("out_clip_z", exp_r.out_clip_z, act.out_clip_z);
          check_field("out_clip_w", exp_r.out_clip_w, act.out_clip_w);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // register write, only issued while the block is drained
  task automatic write_reg(logic [ctdv_pkg::CfgAddrW-1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      ctdv_pkg::RegScaleX:  view_cfg.scale_x = val;
      ctdv_pkg::RegScaleY:  view_cfg.scale_y = val;
      ctdv_pkg::RegScaleZ:  view_cfg.scale_z = val;
      ctdv_pkg::RegOffsetX: view_cfg.offset_x = val;
      ctdv_pkg::RegOffsetY: view_cfg.offset_y = val;
      ctdv_pkg::RegOffsetZ: view_cfg.offset_z = val;
      ctdv_pkg::RegUserMsk: view_cfg.user_plane_mask = val[7:0];
      default: ;  // out of range, ignored by the block
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // float patterns skewed to the interesting corners
  function automatic logic [31:0] pick_float();
    logic s;
    s = $urandom_range(1);
    case ($urandom_range(11))
      0, 1:    return $urandom();
      2:       return {s, 31'd0};
      3:       return {s, 8'hFF, 23'd0};
      4:       return {s, 8'hFF, 23'($urandom_range(32'h7F_FFFF, 1))};
      5:       return {s, 8'd0, 23'($urandom())};
      6:       return {s, 8'($urandom_range(254, 230)), 23'($urandom())};
      default: return {s, 8'($urandom_range(134, 118)), 23'($urandom())};
    endcase
  endfunction

  function automatic logic [31:0] pick_cfg();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h7F7F_FFFF;
      3:       return {1'($urandom_range(1)), 8'hFF, 23'd0};
      4:       return $urandom();
      default: return {1'($urandom_range(1)), 8'($urandom_range(140, 115)), 23'($urandom())};
    endcase
  endfunction

  // a vertex: mostly a plausible scene point near the frustum, some noise
  function automatic logic [127:0] pick_vertex();
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
    if ($urandom_range(3) == 0) begin
      x = pick_float();
      y = pick_float();
      z = pick_float();
      w = pick_float();
    end else begin
      w = {1'($urandom_range(9) == 0), 8'($urandom_range(133, 120)), 23'($urandom())};
      x = {1'($urandom_range(1)), 8'($urandom_range(w[30:23] + 1, 110)), 23'($urandom())};
      y = {1'($urandom_range(1)), 8'($urandom_range(w[30:23] + 1, 110)), 23'($urandom())};
      z = {1'($urandom_range(1)), 8'($urandom_range(w[30:23] + 1, 110)), 23'($urandom())};
      // sit exactly on a plane now and then
      case ($urandom_range(5))
        0: x = w;
        1: y = {~w[31], w[30:0]};
        2: z = w;
        default: ;
      endcase
    end
    return {w, z, y, x};
  endfunction

  task automatic drain();
    while (vertex_q.size() != 0 || s_axis_tvalid || vertex_exp_q.size() != 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic run_phase(int src_pct, int snk_pct, int n_items, bit long_hold);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    for (int i = 0; i < n_items; i++) vertex_q.push_back(pick_vertex());
    if (long_hold) begin
      @(posedge clk_i);
      hold_req = 1'b1;
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    n_fail        = 0;
    hold_req      = 1'b0;
    in_fire       = 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    cfg_valid_i   = 1'b0;
    cfg_addr_i    = ctdv_pkg::RegScaleX;
    cfg_data_i    = '0;
    view_cfg      = '{scale_x: ctdv_pkg::OneFloat, scale_y: ctdv_pkg::OneFloat,
                      scale_z: ctdv_pkg::OneFloat,
                      offset_x: 32'd0, offset_y: 32'd0, offset_z: 32'd0,
                      user_plane_mask: 8'd0};
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed corners under the reset viewport
    vertex_q.push_back({32'h0000_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000}); // +0 w
    vertex_q.push_back({32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h0000_0000}); // -0 w
    vertex_q.push_back({32'h3F80_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000}); // on planes
    vertex_q.push_back({32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000}); // -0 sums
    vertex_q.push_back({32'h7FC0_0001, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000}); // nan w
    vertex_q.push_back({32'h3F80_0000, 32'hFFFF_FFFF, 32'h7F80_0001, 32'h7FFF_FFFF}); // nan xyz
    vertex_q.push_back({32'h7F80_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h3F80_0000}); // inf w
    vertex_q.push_back({32'h0000_0001, 32'h0000_0001, 32'h8000_0001, 32'h007F_FFFF}); // denormal
    vertex_q.push_back({32'h0040_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7F7F_FFFF}); // overflow
    vertex_q.push_back({32'h7F7F_FFFF, 32'h0000_0001, 32'h8000_0001, 32'h0080_0000}); // underflow
    vertex_q.push_back({32'hC000_0000, 32'h4000_0000, 32'hC040_0000, 32'h4080_0000}); // behind
    vertex_q.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    vertex_q.push_back({32'h3F80_0001, 32'h3F7F_FFFF, 32'hBF7F_FFFF, 32'h3F80_0000});
    drain();

    // extreme viewport and full user mask, including an out-of-range index
    write_reg(ctdv_pkg::RegScaleX, 32'h7F7F_FFFF);
    write_reg(ctdv_pkg::RegScaleY, 32'h0000_0001);
    write_reg(ctdv_pkg::RegScaleZ, 32'hFF80_0000);
    write_reg(ctdv_pkg::RegOffsetX, 32'hFFFF_FFFF);
    write_reg(ctdv_pkg::RegOffsetY, 32'h0000_0000);
    write_reg(ctdv_pkg::RegOffsetZ, 32'h7F7F_FFFF);
    write_reg(ctdv_pkg::RegUserMsk, 32'hFFFF_FFFF);
    write_reg(ctdv_pkg::CfgAddrW'(7), 32'h1234_5678);
    vertex_q.push_back({32'h3F80_0000, 32'h3F00_0000, 32'hBF00_0000, 32'h3F00_0000});
    vertex_q.push_back({32'h0000_0000, 32'h3F00_0000, 32'hBF00_0000, 32'h3F00_0000});
    vertex_q.push_back({32'h4000_0000, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000});
    run_phase(0, 0, 40, 1'b0);

    // random phases across all idling styles, fresh viewport each time
    for (int ph = 0; ph < 12; ph++) begin
      for (int r = 0; r < 7; r++) begin
        write_reg(ctdv_pkg::CfgAddrW'(r), (r == 6) ? $urandom() : pick_cfg());
      end
      case (ph % 4)
        0: run_phase(0, 0, 110, ph == 4);
        1: run_phase(57, 0, 110, 1'b0);
        2: run_phase(0, 57, 110, ph == 2);
        default: run_phase(25, 25, 110, 1'b0);
      endcase
    end

    // back to a plain viewport and empty user mask
    write_reg(ctdv_pkg::RegScaleX, ctdv_pkg::OneFloat);
    write_reg(ctdv_pkg::RegScaleY, ctdv_pkg::OneFloat);
    write_reg(ctdv_pkg::RegScaleZ, ctdv_pkg::OneFloat);
    write_reg(ctdv_pkg::RegOffsetX, 32'd0);
    write_reg(ctdv_pkg::RegOffsetY, 32'd0);
    write_reg(ctdv_pkg::RegOffsetZ, 32'd0);
    write_reg(ctdv_pkg::RegUserMsk, 32'd0);
    run_phase(0, 0, 30, 1'b0);

    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog against a hung handshake
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ctdv_pkg.sv
rtl/ctdv_front.sv
rtl/ctdv_queue.sv
rtl/ctdv_lane.sv
rtl/ctdv_back.sv
rtl/clip_test_divide_viewport.sv
dv/tb.sv
